/* sv/jplf_pkg.sv */
// Shared types and constants for the junction pixel label fill block.
// Depends on nothing; imported by junction_pixel_label_fill.
package jplf_pkg;

    // Default line length limit of the line store.
    localparam int MAX_WIDTH_DEF = 1024;

    // Field widths fixed by the pixel and register formats.
    localparam int CH_W       = 8;
    localparam int LABEL_W    = 3 * CH_W;
    localparam int PIX_W      = LABEL_W + 1;
    localparam int IMG_W_BITS = 11;
    localparam int ROW_W      = 16;
    localparam int PR_W       = ROW_W + 1;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Register reset values.
    localparam logic [IMG_W_BITS-1:0] RESET_IMG_W = IMG_W_BITS'(640);
    localparam logic [ROW_W-1:0]      RESET_IMG_H = ROW_W'(480);

    // Skeleton byte value that marks a road pixel.
    localparam logic [CH_W-1:0] THIN_ROAD = 8'd255;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_cfg_reg;

    // Where a result label came from.
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_OWN  = 2'd1,
        SRC_EDGE = 2'd2,
        SRC_DIAG = 2'd3
    } t_source;

    // Setup sequencer: frame size, position divide, window refill, then run.
    typedef enum logic [2:0] {
        S_MUL,
        S_LAST,
        S_DINIT,
        S_DIV,
        S_RD0,
        S_RD1,
        S_RUN
    } t_seq_state;

    // Per-beat control carried from the memory read stage to the result stage.
    typedef struct packed {
        logic has_res;
        logic top;
        logic bot;
        logic lft;
        logic rgt;
        logic frame_end;
    } t_s1_meta;

    // A label counts as set when any channel is nonzero.
    function automatic logic lab_set(input logic [PIX_W-1:0] px);
        return |px[LABEL_W-1:0];
    endfunction

endpackage

/* sv/junction_pixel_label_fill.sv */
// Junction pixel label fill: streaming 3x3 window over a ring line store.
// Depends on jplf_pkg (types, constants, label test function).
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  pixel in | i_in_valid / o_in_ready    | i_thin_value, i_label_ch0..2, i_pad
//  result   | o_out_valid / i_out_ready  | o_out_ch0..2, o_source, o_frame_end
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One pixel beat per clock in steady state while results are taken; a result passes
// through the memory read stage, then the result register. The ring store has one
// write and two read ports, which sets the one-beat-per-cycle figure.
// After reset and after each register write a setup pass (S_MUL, S_LAST, S_DINIT,
// S_DIV, S_RD0, S_RD1) computes the frame size and the position by
// iterative division and refills the window; pixel beats wait during it.
// A stalled result holds the read stage; outside setup the input stalls only when both are full.
module junction_pixel_label_fill
    import jplf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CH_W-1:0]       i_thin_value,
    input  logic [CH_W-1:0]       i_label_ch0,
    input  logic [CH_W-1:0]       i_label_ch1,
    input  logic [CH_W-1:0]       i_label_ch2,
    input  logic                  i_pad,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CH_W-1:0]       o_out_ch0,
    output logic [CH_W-1:0]       o_out_ch1,
    output logic [CH_W-1:0]       o_out_ch2,
    output logic [1:0]            o_source,
    output logic                  o_frame_end,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int XW     = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
    localparam int P_BITS = WW + ROW_W;
    localparam int RING   = 2 * MAX_WIDTH + 4;
    localparam int A_BITS = $clog2(RING);
    localparam int CNT_W  = $clog2(P_BITS + 1);

    // Configuration and derived frame size.
    logic [IMG_W_BITS-1:0] r_img_w;
    logic [ROW_W-1:0]      r_img_h;
    logic [XW-1:0]         w_raw_x;
    logic [XW-1:0]         weff_x;
    logic [WW-1:0]         weff;
    logic [ROW_W-1:0]      heff;
    logic [P_BITS-1:0]     r_area;
    logic [P_BITS-1:0]     r_last;

    // Stream position: linear index, ring pointer, and row/column of the index.
    logic [P_BITS-1:0] r_p;
    logic [A_BITS-1:0] r_ptr;
    logic [PR_W-1:0]   r_pr;
    logic [WW-1:0]     r_pc;
    logic              wrap_cnt;
    logic [P_BITS-1:0] p_eff;
    logic [A_BITS-1:0] ptr_eff;

    // Sequencer.
    t_seq_state r_state;
    t_seq_state n_state;
    logic       fill_rd;
    logic [1:0] rd_off;
    logic       r_fill_ld;

    // Divider.
    logic [P_BITS-1:0] r_dq;
    logic [WW:0]       r_rem;
    logic [CNT_W-1:0]  r_dcnt;
    logic [WW:0]       rem_sh;
    logic              div_ge;
    logic [WW:0]       rem_n;
    logic [P_BITS-1:0] dq_n;

    // Line store and its read ports.
    logic [PIX_W-1:0]  r_line_mem [RING];
    logic [PIX_W-1:0]  r_rd_up;
    logic [PIX_W-1:0]  r_rd_mid;
    logic [A_BITS:0]   k_mid;
    logic [A_BITS:0]   k_up;
    logic [A_BITS:0]   d_mid;
    logic [A_BITS:0]   d_up;
    logic [A_BITS-1:0] addr_mid;
    logic [A_BITS-1:0] addr_up;
    logic              rd_en;

    // Handshakes and pipeline stages.
    logic             in_acc;
    logic             cfg_acc;
    logic             s1_move;
    logic             r_s1_valid;
    t_s1_meta         r_s1;
    t_s1_meta         n_s1;
    logic [PIX_W-1:0] r_s1_pix;
    logic [PIX_W-1:0] pix_in;
    logic             r_out_valid;

    // Window columns 0 and 1; column 2 is the read data and the stage pixel.
    logic [PIX_W-1:0] r_up0, r_up1, r_mid0, r_mid1, r_dn0, r_dn1;

    // Centre position and result.
    logic [WW-1:0]      q_col;
    logic [PR_W-1:0]    q_row;
    logic [PR_W-1:0]    hm1;
    logic [LABEL_W-1:0] res_lab;
    t_source            res_src;
    logic [LABEL_W-1:0] r_out_lab;
    t_source            r_out_src;
    logic               r_out_fe;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && o_in_ready;

    // Effective frame size: width zero counts as one and saturates at the limit.
    assign w_raw_x = XW'(r_img_w);
    always_comb begin
        if (w_raw_x == '0) begin
            weff_x = XW'(1);
        end else if (w_raw_x > XW'(MAX_WIDTH)) begin
            weff_x = XW'(MAX_WIDTH);
        end else begin
            weff_x = w_raw_x;
        end
    end
    assign weff = weff_x[WW-1:0];
    assign heff = (r_img_h == '0) ? ROW_W'(1) : r_img_h;
    assign hm1  = PR_W'(heff) - PR_W'(1);

    // A register change can leave the index past the flush region; it restarts then.
    assign wrap_cnt = (r_p > r_last);
    assign p_eff    = wrap_cnt ? '0 : r_p;
    assign ptr_eff  = wrap_cnt ? '0 : r_ptr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RESET_IMG_W;
            r_img_h <= RESET_IMG_H;
        end else if (cfg_acc) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_MUL;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and refill read controls.
    always_comb begin
        n_state = r_state;
        fill_rd = 1'b0;
        rd_off  = 2'd0;
        case (r_state)
            S_MUL:   n_state = S_LAST;
            S_LAST:  n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV: begin
                if (r_dcnt == CNT_W'(P_BITS - 1)) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                fill_rd = 1'b1;
                rd_off  = 2'd2;
                n_state = S_RD1;
            end
            S_RD1: begin
                fill_rd = 1'b1;
                rd_off  = 2'd1;
                n_state = S_RUN;
            end
            S_RUN:   n_state = S_RUN;
            default: n_state = S_MUL;
        endcase
        if (cfg_acc) begin
            n_state = S_MUL;
        end
    end

    // Frame area and the index of the last flush beat.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_area <= P_BITS'(weff) * P_BITS'(heff);
        end
        if (r_state == S_LAST) begin
            r_last <= r_area + P_BITS'(weff);
        end
    end

    // Restoring divider: row and column of the current index, one bit a cycle.
    assign rem_sh = {r_rem[WW-1:0], r_dq[P_BITS-1]};
    assign div_ge = (rem_sh >= {1'b0, weff});
    assign rem_n  = div_ge ? (rem_sh - {1'b0, weff}) : rem_sh;
    assign dq_n   = {r_dq[P_BITS-2:0], div_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (r_state == S_DINIT) begin
            r_dq   <= p_eff;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (r_state == S_DIV) begin
            r_dq   <= dq_n;
            r_rem  <= rem_n;
            r_dcnt <= r_dcnt + CNT_W'(1);
        end
    end

    // Stream position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p   <= '0;
            r_ptr <= '0;
            r_pr  <= '0;
            r_pc  <= '0;
        end else if (r_state == S_DIV && r_dcnt == CNT_W'(P_BITS - 1)) begin
            r_pr <= dq_n[PR_W-1:0];
            r_pc <= rem_n[WW-1:0];
        end else if (in_acc) begin
            if (p_eff == r_last) begin
                r_p   <= '0;
                r_ptr <= '0;
                r_pr  <= '0;
                r_pc  <= '0;
            end else begin
                r_p   <= p_eff + P_BITS'(1);
                r_ptr <= (ptr_eff == A_BITS'(RING - 1)) ? '0 : ptr_eff + A_BITS'(1);
                if (r_pc == weff - WW'(1)) begin
                    r_pc <= '0;
                    r_pr <= r_pr + PR_W'(1);
                end else begin
                    r_pc <= r_pc + WW'(1);
                end
            end
        end
    end

    // Read addresses one and two rows back, modulo the ring size.
    always_comb begin
        k_mid = (A_BITS+1)'(weff) + (A_BITS+1)'(rd_off);
        k_up  = ((A_BITS+1)'(weff) << 1) + (A_BITS+1)'(rd_off);
        d_mid = {1'b0, ptr_eff} - k_mid;
        d_up  = {1'b0, ptr_eff} - k_up;
        if (d_mid[A_BITS]) begin
            d_mid = d_mid + (A_BITS+1)'(RING);
        end
        if (d_up[A_BITS]) begin
            d_up = d_up + (A_BITS+1)'(RING);
        end
    end
    assign addr_mid = d_mid[A_BITS-1:0];
    assign addr_up  = d_up[A_BITS-1:0];
    assign rd_en    = in_acc || fill_rd;

    // Pad beats and beats past the image are stored blank.
    always_comb begin
        if (i_pad || p_eff >= r_area) begin
            pix_in = '0;
        end else begin
            pix_in = {(i_thin_value == THIN_ROAD), i_label_ch2, i_label_ch1, i_label_ch0};
        end
    end

    // Line store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line_mem[ptr_eff] <= pix_in;
        end
        if (rd_en) begin
            r_rd_up  <= r_line_mem[addr_up];
            r_rd_mid <= r_line_mem[addr_mid];
        end
    end

    // Centre position (one row plus one pixel behind) and its border flags.
    always_comb begin
        if (r_pc == '0) begin
            q_col = weff - WW'(1);
            q_row = r_pr - PR_W'(2);
        end else begin
            q_col = r_pc - WW'(1);
            q_row = r_pr - PR_W'(1);
        end
        n_s1.has_res   = (r_pr >= PR_W'(2)) || (r_pr == PR_W'(1) && r_pc != '0);
        n_s1.top       = (q_row != '0);
        n_s1.bot       = (q_row < hm1);
        n_s1.lft       = (q_col != '0);
        n_s1.rgt       = (q_col != weff - WW'(1));
        n_s1.frame_end = (q_row == hm1) && (q_col == weff - WW'(1));
    end

    // Pipeline control: the read stage moves when it carries no result or the result register can take it.
    assign s1_move    = r_s1_valid && (!r_s1.has_res || !r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_RUN) && (!r_s1_valid || s1_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1     <= n_s1;
            r_s1_pix <= pix_in;
        end
    end

    // Window shift on each beat; refill reads shift only the upper two rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_ld <= 1'b0;
            r_up0     <= '0;
            r_up1     <= '0;
            r_mid0    <= '0;
            r_mid1    <= '0;
            r_dn0     <= '0;
            r_dn1     <= '0;
        end else begin
            r_fill_ld <= fill_rd;
            if (s1_move || r_fill_ld) begin
                r_up0  <= r_up1;
                r_up1  <= r_rd_up;
                r_mid0 <= r_mid1;
                r_mid1 <= r_rd_mid;
            end
            if (s1_move) begin
                r_dn0 <= r_dn1;
                r_dn1 <= r_s1_pix;
            end
        end
    end

    // Label choice: own label, else last edge neighbour, else first diagonal.
    always_comb begin
        logic e_up, e_lf, e_rt, e_dn;
        logic g_ul, g_ur, g_dl, g_dr;
        e_up    = r_s1.top && lab_set(r_up1);
        e_lf    = r_s1.lft && lab_set(r_mid0);
        e_rt    = r_s1.rgt && lab_set(r_rd_mid);
        e_dn    = r_s1.bot && lab_set(r_dn1);
        g_ul    = r_s1.top && r_s1.lft && lab_set(r_up0);
        g_ur    = r_s1.top && r_s1.rgt && lab_set(r_rd_up);
        g_dl    = r_s1.bot && r_s1.lft && lab_set(r_dn0);
        g_dr    = r_s1.bot && r_s1.rgt && lab_set(r_s1_pix);
        res_lab = '0;
        res_src = SRC_NONE;
        if (lab_set(r_mid1)) begin
            res_lab = r_mid1[LABEL_W-1:0];
            res_src = SRC_OWN;
        end else if (r_mid1[LABEL_W]) begin
            if (e_dn) begin
                res_lab = r_dn1[LABEL_W-1:0];
                res_src = SRC_EDGE;
            end else if (e_rt) begin
                res_lab = r_rd_mid[LABEL_W-1:0];
                res_src = SRC_EDGE;
            end else if (e_lf) begin
                res_lab = r_mid0[LABEL_W-1:0];
                res_src = SRC_EDGE;
            end else if (e_up) begin
                res_lab = r_up1[LABEL_W-1:0];
                res_src = SRC_EDGE;
            end else if (g_ul) begin
                res_lab = r_up0[LABEL_W-1:0];
                res_src = SRC_DIAG;
            end else if (g_ur) begin
                res_lab = r_rd_up[LABEL_W-1:0];
                res_src = SRC_DIAG;
            end else if (g_dl) begin
                res_lab = r_dn0[LABEL_W-1:0];
                res_src = SRC_DIAG;
            end else if (g_dr) begin
                res_lab = r_s1_pix[LABEL_W-1:0];
                res_src = SRC_DIAG;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && r_s1.has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1.has_res) begin
            r_out_lab <= res_lab;
            r_out_src <= res_src;
            r_out_fe  <= r_s1.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_ch0   = r_out_lab[CH_W-1:0];
    assign o_out_ch1   = r_out_lab[2*CH_W-1:CH_W];
    assign o_out_ch2   = r_out_lab[3*CH_W-1:2*CH_W];
    assign o_source    = r_out_src;
    assign o_frame_end = r_out_fe;

    // The beat that closes the flush region restarts every position counter.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && p_eff == r_last) |=> (r_p == '0 && r_ptr == '0 && r_pr == '0 && r_pc == '0))
        else $error("position counters did not restart after the last flush beat");

    // While running, the column counter stays inside the row and the ring pointer inside the ring.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_pc < weff && r_ptr < A_BITS'(RING)))
        else $error("column or ring pointer out of range");

    // A result without a source carries a zero label.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_source == SRC_NONE) |-> (r_out_lab == '0))
        else $error("unlabelled result carries a nonzero label");

endmodule

/* tb/tb.sv */
// Self-checking bench for junction_pixel_label_fill: pixel beats in, filled labels out.
// Depends on jplf_pkg and the junction_pixel_label_fill RTL; the labels are predicted here.
// Directed frames first, then random raster frames under several idle and stall patterns.
module tb;
    import jplf_pkg::*;

    localparam int RING_DEPTH    = 2 * MAX_WIDTH_DEF + 4;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;

    // Register indexes that the block leaves unused.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] thin;
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic            pad;
    } t_pixel_beat;

    typedef struct packed {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        t_source         src;
        logic            frame_end;
    } t_fill_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [CH_W-1:0]       i_thin_value = '0;
    logic [CH_W-1:0]       i_label_ch0 = '0;
    logic [CH_W-1:0]       i_label_ch1 = '0;
    logic [CH_W-1:0]       i_label_ch2 = '0;
    logic                  i_pad = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [CH_W-1:0]       o_out_ch0;
    logic [CH_W-1:0]       o_out_ch1;
    logic [CH_W-1:0]       o_out_ch2;
    logic [1:0]            o_source;
    logic                  o_frame_end;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Pixels waiting to be driven and labels waiting to come out.
    t_pixel_beat  pixel_backlog[$];
    t_fill_result pending_labels[$];

    // Shadow of the block: registers, raster position and the recent pixels.
    logic [IMG_W_BITS-1:0] width_reg = RESET_IMG_W;
    logic [ROW_W-1:0]      height_reg = RESET_IMG_H;
    int unsigned           frame_pos = 0;
    logic [PIX_W-1:0]      ring_store [RING_DEPTH];

    int  send_gap_pct = 0;
    int  recv_stall_pct = 0;
    int  mismatch_cnt = 0;
    int  cycle_cnt = 0;
    int  hold_left = 0;
    bit  hold_tog = 1'b0;
    bit  hold_seen = 1'b0;

    junction_pixel_label_fill i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_thin_value (i_thin_value),
        .i_label_ch0  (i_label_ch0),
        .i_label_ch1  (i_label_ch1),
        .i_label_ch2  (i_label_ch2),
        .i_pad        (i_pad),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_ch0    (o_out_ch0),
        .o_out_ch1    (o_out_ch1),
        .o_out_ch2    (o_out_ch2),
        .o_source     (o_source),
        .o_frame_end  (o_frame_end),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock with a period of 8.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Width as the block uses it: zero means one, large values saturate.
    function automatic int unsigned eff_width();
        if (width_reg == '0) return 1;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == '0) ? 1 : height_reg;
    endfunction

    // Append one pixel beat to the driver backlog.
    function automatic void add_pixel_beat(input t_pixel_beat px);
        pixel_backlog = {pixel_backlog, px};
    endfunction

    // Label of a pixel in the current frame; nothing outside the image.
    function automatic logic [LABEL_W-1:0] label_near(input int r, input int c,
                                                      input int unsigned w,
                                                      input int unsigned h);
        if (r < 0 || c < 0 || r >= int'(h) || c >= int'(w)) return '0;
        return ring_store[(r * w + c) % RING_DEPTH][LABEL_W-1:0];
    endfunction

    // Store one accepted pixel and queue the label of the centre one row plus one behind.
    function automatic void predict_label_fill(input t_pixel_beat px);
        int unsigned      w, h, area, last_pos, p, q;
        int               r, c, k;
        logic [PIX_W-1:0] pix, centre;
        logic [LABEL_W-1:0] res;
        logic [LABEL_W-1:0] side_nb [4];
        logic [LABEL_W-1:0] diag_nb [4];
        t_source          src;
        t_fill_result     rec;
        w = eff_width();
        h = eff_height();
        area = w * h;
        last_pos = area + w;
        if (frame_pos > last_pos) frame_pos = 0;
        p = frame_pos;
        // Pad beats and the flush region are stored blank.
        if (px.pad || p >= area) pix = '0;
        else pix = {px.thin == THIN_ROAD, px.ch2, px.ch1, px.ch0};
        ring_store[p % RING_DEPTH] = pix;
        frame_pos = (p >= last_pos) ? 0 : p + 1;
        if (p < w + 1) return;
        q = p - w - 1;
        r = q / w;
        c = q % w;
        centre = ring_store[q % RING_DEPTH];
        res = '0;
        src = SRC_NONE;
        if (centre[LABEL_W-1:0] != '0) begin
            res = centre[LABEL_W-1:0];
            src = SRC_OWN;
        end else if (centre[LABEL_W]) begin
            // Edge neighbours: the last labelled one in scan order wins.
            side_nb[0] = label_near(r - 1, c, w, h);
            side_nb[1] = label_near(r, c - 1, w, h);
            side_nb[2] = label_near(r, c + 1, w, h);
            side_nb[3] = label_near(r + 1, c, w, h);
            for (k = 0; k < 4; k++) begin
                if (side_nb[k] != '0) begin
                    res = side_nb[k];
                    src = SRC_EDGE;
                end
            end
            // Diagonals only as a fallback: the first labelled one wins.
            if (src == SRC_NONE) begin
                diag_nb[0] = label_near(r - 1, c - 1, w, h);
                diag_nb[1] = label_near(r - 1, c + 1, w, h);
                diag_nb[2] = label_near(r + 1, c - 1, w, h);
                diag_nb[3] = label_near(r + 1, c + 1, w, h);
                for (k = 3; k >= 0; k--) begin
                    if (diag_nb[k] != '0) begin
                        res = diag_nb[k];
                        src = SRC_DIAG;
                    end
                end
            end
        end
        rec.ch0 = res[7:0];
        rec.ch1 = res[15:8];
        rec.ch2 = res[23:16];
        rec.src = src;
        rec.frame_end = (q == area - 1);
        pending_labels = {pending_labels, rec};
    endfunction

    // Random pixel: half road pixels and many blank labels, so the fill paths get used.
    function automatic t_pixel_beat rand_pixel();
        t_pixel_beat px;
        int          roll;
        roll = $urandom_range(9);
        if (roll < 5) px.thin = THIN_ROAD;
        else if (roll == 5) px.thin = 8'd254;
        else px.thin = CH_W'($urandom_range(255));
        if ($urandom_range(99) < 55) begin
            px.ch0 = '0;
            px.ch1 = '0;
            px.ch2 = '0;
        end else begin
            px.ch0 = ($urandom_range(3) == 0) ? '0 : CH_W'($urandom_range(255));
            px.ch1 = ($urandom_range(3) == 0) ? '0 : CH_W'($urandom_range(255));
            px.ch2 = ($urandom_range(3) == 0) ? '0 : CH_W'($urandom_range(255));
        end
        px.pad = 1'b0;
        return px;
    endfunction

    task automatic push_pixel(input logic [CH_W-1:0] thin, input logic [CH_W-1:0] c0,
                              input logic [CH_W-1:0] c1, input logic [CH_W-1:0] c2,
                              input logic pad);
        t_pixel_beat px;
        px.thin = thin;
        px.ch0 = c0;
        px.ch1 = c1;
        px.ch2 = c2;
        px.pad = pad;
        add_pixel_beat(px);
    endtask

    // Whole frames with flush beats; now and then stray pads or extra beats break the raster.
    task automatic queue_frames(input int n_items);
        int          w, h, total, k;
        t_pixel_beat px;
        w = eff_width();
        h = eff_height();
        total = 0;
        while (total < n_items) begin
            for (k = 0; k < w * h + w + 1; k++) begin
                px = rand_pixel();
                if (k >= w * h) begin
                    if ($urandom_range(19) != 0) px.pad = 1'b1;
                end else if ($urandom_range(32) == 0) begin
                    px.pad = 1'b1;
                end
                add_pixel_beat(px);
            end
            total += w * h + w + 1;
            if ($urandom_range(15) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    add_pixel_beat(rand_pixel());
                    total++;
                end
            end
        end
    endtask

    // Plain pixel stream with no frame structure, for the largest sizes.
    task automatic queue_stream(input int n_items);
        t_pixel_beat px;
        repeat (n_items) begin
            px = rand_pixel();
            px.pad = ($urandom_range(40) == 0);
            add_pixel_beat(px);
        end
    endtask

    // One register write beat; the shadow copy follows once the beat is taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_IMAGE_WIDTH) width_reg = data[IMG_W_BITS-1:0];
        else if (idx == REG_IMAGE_HEIGHT) height_reg = data;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // New frame size once the block has gone quiet.
    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic wait_drained();
        while (pixel_backlog.size() != 0 || i_in_valid || pending_labels.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_gap_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Pixel driver: a new beat only when the previous one has been taken.
    always @(posedge i_clk) begin : pixel_driver
        t_pixel_beat nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                nxt = pixel_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_thin_value <= nxt.thin;
                i_label_ch0 <= nxt.ch0;
                i_label_ch1 <= nxt.ch1;
                i_label_ch2 <= nxt.ch2;
                i_pad <= nxt.pad;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started by a toggle from the stimulus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: predicts from accepted pixel beats and checks each result beat.
    always @(posedge i_clk) begin : label_monitor
        t_pixel_beat  seen;
        t_fill_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                seen.thin = i_thin_value;
                seen.ch0 = i_label_ch0;
                seen.ch1 = i_label_ch1;
                seen.ch2 = i_label_ch2;
                seen.pad = i_pad;
                predict_label_fill(seen);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_labels.size() == 0) begin
                    $error("result beat with no label expected");
                    mismatch_cnt++;
                end else begin
                    want = pending_labels.pop_front();
                    if (o_out_ch0 !== want.ch0) begin
                        $error("out_ch0 mismatch: expected %0d, got %0d", want.ch0, o_out_ch0);
                        mismatch_cnt++;
                    end
                    if (o_out_ch1 !== want.ch1) begin
                        $error("out_ch1 mismatch: expected %0d, got %0d", want.ch1, o_out_ch1);
                        mismatch_cnt++;
                    end
                    if (o_out_ch2 !== want.ch2) begin
                        $error("out_ch2 mismatch: expected %0d, got %0d", want.ch2, o_out_ch2);
                        mismatch_cnt++;
                    end
                    if (o_source !== want.src) begin
                        $error("source mismatch: expected %0d, got %0d", want.src, o_source);
                        mismatch_cnt++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $error("frame_end mismatch: expected %0d, got %0d",
                               want.frame_end, o_frame_end);
                        mismatch_cnt++;
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        foreach (ring_store[i]) ring_store[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed 3x3 frame: own label, last edge wins, diagonal fallback,
        // road with nothing near, pad inside the frame, flush beat with data.
        set_idle(0, 0);
        set_frame(3, 3);
        push_pixel(8'd0,   8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd255, 8'd9,   8'd9,   8'd9,   1'b1);
        push_pixel(8'd255, 8'd1,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd254, 8'd0,   8'd0,   8'd128, 1'b0);
        push_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
        push_pixel(8'd255, 8'd200, 8'd100, 8'd50,  1'b0);
        push_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
        push_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
        wait_drained();

        // Single-column frame; the first flush beat carries data that must be ignored.
        set_frame(1, 2);
        push_pixel(8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd0,   8'd0,   8'd77,  8'd0,   1'b0);
        push_pixel(8'd255, 8'd3,   8'd3,   8'd3,   1'b0);
        push_pixel(8'd255, 8'd0,   8'd0,   8'd0,   1'b1);
        wait_drained();

        // Random frames; the receiver holds off long while the sender keeps going.
        set_idle(0, 0);
        set_frame(8, 6);
        queue_frames(100);
        hold_tog <= ~hold_tog;
        wait_drained();

        set_idle(57, 0);
        set_frame(5, 7);
        queue_frames(100);
        wait_drained();

        // One-pixel frames, with the receiver often stalling and a full drain midway.
        set_idle(0, 57);
        set_frame(1, 1);
        queue_frames(40);
        wait_drained();
        queue_frames(40);
        wait_drained();

        // Zero sizes count as one.
        set_idle(20, 20);
        set_frame(16'd0, 16'd0);
        queue_frames(40);
        wait_drained();

        set_idle(57, 0);
        set_frame(37, 4);
        queue_frames(100);
        wait_drained();

        set_idle(0, 57);
        set_frame(2, 9);
        queue_frames(60);
        wait_drained();

        // Largest sizes: width saturates, only the first rows are streamed.
        set_idle(0, 0);
        set_frame(16'hFFFF, 16'hFFFF);
        queue_stream(1050);
        wait_drained();

        // Writes to unused indexes leave the frame size alone.
        set_idle(20, 20);
        set_frame(3, 1);
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h0000);
        queue_frames(40);
        wait_drained();

        set_idle(0, 0);
        set_frame(13, 5);
        queue_frames(100);
        hold_tog <= ~hold_tog;
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/jplf_pkg.sv
sv/junction_pixel_label_fill.sv
tb/tb.sv
